>>> rtl/per_source_latency_stats_defines.svh
// assertion macros for the per-source latency statistics checker
// no dependencies; expects clk and rst_n in the scope of use
`ifndef PER_SOURCE_LATENCY_STATS_DEFINES_SVH
`define PER_SOURCE_LATENCY_STATS_DEFINES_SVH

// same-cycle implication, off during reset
`define PSLS_IMPLIES(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("psls check failed: same-cycle implication");

// next-cycle implication, off during reset
`define PSLS_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("psls check failed: next-cycle implication");

`endif

>>> rtl/psls_pkg.sv
// types and constants for the per-source latency statistics block
// no dependencies
`default_nettype none

package psls_pkg;

    localparam int COUNT_W = 24;
    localparam int DELAY_W = 32;
    localparam int SUM_W   = 56;
    localparam int INDEX_W = 4;
    localparam int KIND_W  = 2;

    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    // request kinds
    localparam logic [KIND_W-1:0] REQ_PRODUCE = 2'd0;
    localparam logic [KIND_W-1:0] REQ_CONSUME = 2'd1;
    localparam logic [KIND_W-1:0] REQ_READ    = 2'd2;

    typedef struct packed {
        logic [KIND_W-1:0]  req_type;
        logic [INDEX_W-1:0] source_index;
        logic [DELAY_W-1:0] delay;
    } req_t;

    typedef struct packed {
        logic [COUNT_W-1:0] made_total;
        logic [COUNT_W-1:0] eaten_total;
        logic [DELAY_W-1:0] min_latency;
        logic [DELAY_W-1:0] avg_latency;
        logic [DELAY_W-1:0] max_latency;
        logic               has_samples;
        logic               count_mismatch;
    } res_t;

    // one table entry
    typedef struct packed {
        logic [COUNT_W-1:0] made;
        logic [COUNT_W-1:0] eaten;
        logic [DELAY_W-1:0] min_d;
        logic [DELAY_W-1:0] max_d;
        logic [SUM_W-1:0]   sum;
    } entry_t;

endpackage

`default_nettype wire

>>> rtl/per_source_latency_stats.sv
// per-source latency statistics: table, update logic, bit-serial divider
// depends on psls_pkg
//
//  channel   | ports                         | handshake
//  ----------+-------------------------------+----------------------------------
//  request   | start, busy, req (req_t)      | transfer when start & !busy
//  result    | done, result (res_t)          | one-cycle strobe, cannot stall
//
// an item goes through the table read at the transfer, then the update and
// write-back, and, only when the entry has samples, the restoring divider
// that produces one quotient bit per cycle
// busy is high from the transfer until the result strobe
// reset clears the table through per-entry valid bits, no clearing pass
// the result is held until the next item updates it; the receiver must take it
`default_nettype none

module per_source_latency_stats
    import psls_pkg::*;
#(
    parameter int SOURCES = 16
) (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic start,
    output logic      busy,
    input  wire req_t req,
    output logic      done,
    output res_t      result
);

    localparam int ADDR_W = (SOURCES > 1) ? $clog2(SOURCES) : 1;
    localparam int QBITS  = DELAY_W;
    localparam int CNT_W  = $clog2(QBITS);
    localparam int HIGH_W = SUM_W - DELAY_W;

    // one-hot sequencer
    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_UPDATE = 3'b010,
        S_DIVIDE = 3'b100
    } state_t;

    state_t state_reg, state_next;

    logic accept;
    assign accept = start && (state_reg == S_IDLE);
    assign busy   = (state_reg != S_IDLE);

    // address of the request, zero-extended or cut to the table width
    logic [ADDR_W+INDEX_W-1:0] idx_wide;
    logic [ADDR_W-1:0]         addr;
    logic                      in_range;
    assign idx_wide = {{ADDR_W{1'b0}}, req.source_index};
    assign addr     = idx_wide[ADDR_W-1:0];
    assign in_range = (32'(req.source_index) < SOURCES);

    // captured request
    req_t              req_reg;
    logic [ADDR_W-1:0] addr_reg;
    logic              in_range_reg;

    // statistics table and its read port
    entry_t mem [SOURCES];
    entry_t rd_entry_reg;
    logic   rd_valid_reg;
    logic [SOURCES-1:0] valid_reg;

    // updated entry, built from the entry read at the transfer
    entry_t cur;
    entry_t upd;
    logic   wr_en;

    always_comb
    begin
        cur = rd_valid_reg ? rd_entry_reg : '0;
        upd = cur;
        unique case (req_reg.req_type)
            REQ_PRODUCE:
            begin
                if (cur.made != COUNT_MAX)
                begin
                    upd.made = cur.made + COUNT_W'(1);
                end
            end
            REQ_CONSUME:
            begin
                // first sample seeds both extremes
                if (cur.eaten == '0)
                begin
                    upd.min_d = req_reg.delay;
                    upd.max_d = req_reg.delay;
                end
                else
                begin
                    if (req_reg.delay < cur.min_d)
                    begin
                        upd.min_d = req_reg.delay;
                    end
                    if (req_reg.delay > cur.max_d)
                    begin
                        upd.max_d = req_reg.delay;
                    end
                end
                // at a saturated count the sum freezes
                if (cur.eaten != COUNT_MAX)
                begin
                    upd.eaten = cur.eaten + COUNT_W'(1);
                    upd.sum   = cur.sum + {{HIGH_W{1'b0}}, req_reg.delay};
                end
            end
            default:
            begin
                // read, and the unused kind, change nothing
                upd = cur;
            end
        endcase
    end

    assign wr_en = (state_reg == S_UPDATE) && in_range_reg;

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rd_entry_reg <= mem[addr];
        end
        if (wr_en)
        begin
            mem[addr_reg] <= upd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (wr_en)
        begin
            valid_reg[addr_reg] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg      <= req;
            addr_reg     <= addr;
            in_range_reg <= in_range;
            rd_valid_reg <= in_range && valid_reg[addr];
        end
    end

    // restoring divider: remainder starts at the high sum bits, which are
    // below the count, so only the 32 low bits need quotient steps
    logic [COUNT_W-1:0] rem_reg, rem_next;
    logic [QBITS-1:0]   num_reg, num_next;
    logic [COUNT_W-1:0] dvsr_reg;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [COUNT_W:0]   trial;
    logic [COUNT_W:0]   diff;
    logic               qbit;

    assign trial = {rem_reg, num_reg[QBITS-1]};
    assign diff  = trial - {1'b0, dvsr_reg};
    assign qbit  = (trial >= {1'b0, dvsr_reg});

    // result register and strobe
    res_t result_reg, result_next;
    logic done_reg, done_next;

    always_comb
    begin
        state_next  = state_reg;
        rem_next    = rem_reg;
        num_next    = num_reg;
        cnt_next    = cnt_reg;
        result_next = result_reg;
        done_next   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_UPDATE;
                end
            end
            S_UPDATE:
            begin
                result_next = '0;
                if (in_range_reg)
                begin
                    result_next.made_total     = upd.made;
                    result_next.eaten_total    = upd.eaten;
                    result_next.count_mismatch = (upd.made != upd.eaten);
                    if (upd.eaten != '0)
                    begin
                        result_next.min_latency = upd.min_d;
                        result_next.max_latency = upd.max_d;
                        result_next.has_samples = 1'b1;
                    end
                end
                if (in_range_reg && (upd.eaten != '0))
                begin
                    rem_next   = upd.sum[SUM_W-1:DELAY_W];
                    num_next   = upd.sum[DELAY_W-1:0];
                    cnt_next   = CNT_W'(QBITS - 1);
                    state_next = S_DIVIDE;
                end
                else
                begin
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_DIVIDE:
            begin
                rem_next = qbit ? diff[COUNT_W-1:0] : trial[COUNT_W-1:0];
                num_next = {num_reg[QBITS-2:0], qbit};
                cnt_next = cnt_reg - CNT_W'(1);
                if (cnt_reg == '0)
                begin
                    result_next.avg_latency = num_next;
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
            cnt_reg   <= cnt_next;
        end
    end

    // divisor is the updated eaten count, taken at the update step
    always_ff @(posedge clk)
    begin
        rem_reg    <= rem_next;
        num_reg    <= num_next;
        result_reg <= result_next;
        if (state_reg == S_UPDATE)
        begin
            dvsr_reg <= upd.eaten;
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

`default_nettype wire

>>> rtl/psls_checker.sv
// port-level checker for per_source_latency_stats, with its bind
// depends on psls_pkg and per_source_latency_stats_defines.svh
`default_nettype none

`include "per_source_latency_stats_defines.svh"

module psls_checker
    import psls_pkg::*;
(
    input wire logic clk,
    input wire logic rst_n,
    input wire logic start,
    input wire logic busy,
    input wire logic done,
    input wire res_t result
);

    logic lat_zero;
    logic counts_differ;

    assign lat_zero      = (result.min_latency == '0) && (result.avg_latency == '0)
                           && (result.max_latency == '0);
    assign counts_differ = (result.made_total != result.eaten_total);

    // a transfer keeps the block busy in the next cycle
    `PSLS_NEXT(a_accept_busy, start && !busy, busy)

    // the strobe comes as the block frees up
    `PSLS_IMPLIES(a_done_free, done, !busy)

    // strobe lasts one cycle
    `PSLS_NEXT(a_done_pulse, done, !done)

    // latency fields are zero without samples
    `PSLS_IMPLIES(a_empty_zero, done && !result.has_samples, lat_zero)

    // mismatch flag agrees with the counts
    `PSLS_IMPLIES(a_mismatch, done, result.count_mismatch == counts_differ)

endmodule

bind per_source_latency_stats psls_checker u_psls_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .done   (done),
    .result (result)
);

`default_nettype wire
